[hdl/iekd_pkg.sv]
// Package for the input event key decoder: codes, record type, key code table.
package iekd_pkg;

	// Action codes of the input stream
	typedef enum logic [1:0] {
		ACT_DATA       = 2'd0,
		ACT_CONNECT    = 2'd1,
		ACT_DISCONNECT = 2'd2
	} action_t;

	// Packet type codes found at offset 8
	localparam logic [7:0] TYPE_SYNC   = 8'h00;
	localparam logic [7:0] TYPE_KEY    = 8'h01;
	localparam logic [7:0] TYPE_ABS    = 8'h03;
	localparam logic [7:0] TYPE_KEYABS = 8'h04;

	// Packet layout
	localparam int POS_W         = 5;
	localparam logic [POS_W-1:0] POS_TYPE      = 5'd8;
	localparam logic [POS_W-1:0] POS_LAST_SHORT = 5'd15;
	localparam logic [POS_W-1:0] POS_LAST_LONG  = 5'd31;

	// Adler-32 modulus
	localparam logic [16:0] ADLER_MOD = 17'd65521;

	// LED word widths and codes
	localparam int LED_W = 9;
	localparam logic [LED_W-1:0] LED_DISCONNECT = 9'h100;

	// Record passed from the front to the back
	typedef enum logic [1:0] {
		REC_PACKET     = 2'd0,
		REC_CONNECT    = 2'd1,
		REC_DISCONNECT = 2'd2
	} rec_kind_t;

	typedef struct packed {
		rec_kind_t   kind;
		logic [31:0] sum;
		logic        unexp;
	} record_t;

	// Record queue depth
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// Key code table
	localparam int NUM_CODES = 30;

	typedef struct packed {
		logic [31:0] code;
		logic [7:0]  and_mask;
		logic [7:0]  or_mask;
	} key_code_t;

	localparam key_code_t KEY_TABLE [NUM_CODES] = '{
		'{32'h002e0005, 8'hFF, 8'h80}, '{32'h042a0104, 8'hFF, 8'h20},
		'{32'h022a0084, 8'h5F, 8'h00}, '{32'h00280004, 8'hFF, 8'h40},
		'{32'h04240103, 8'hFF, 8'h10}, '{32'h02240083, 8'hAF, 8'h00},
		'{32'h032f0046, 8'hFF, 8'h08}, '{32'h032b0045, 8'hF7, 8'h00},
		'{32'h03490048, 8'hFF, 8'h04}, '{32'h03450047, 8'hFB, 8'h00},
		'{32'h02790038, 8'hFF, 8'h02}, '{32'h02750037, 8'hFD, 8'h00},
		'{32'h025f0036, 8'hFF, 8'h01}, '{32'h025b0035, 8'hFE, 8'h00},
		'{32'h0a3400cb, 8'hFF, 8'h80}, '{32'h0a3000ca, 8'h7F, 8'h00},
		'{32'h0a1800cb, 8'hFF, 8'h40}, '{32'h0a1400ca, 8'hBF, 8'h00},
		'{32'h0a3e00cf, 8'hFF, 8'h20}, '{32'h0a3a00ce, 8'hDF, 8'h00},
		'{32'h0a0a00cb, 8'hFF, 8'h10}, '{32'h0a0600ca, 8'hEF, 8'h00},
		'{32'h06280077, 8'hFF, 8'h08}, '{32'h06240076, 8'hF7, 8'h00},
		'{32'h052a0056, 8'hFF, 8'h04}, '{32'h05260055, 8'hFB, 8'h00},
		'{32'h02660034, 8'hFF, 8'h02}, '{32'h02620033, 8'hFD, 8'h00},
		'{32'h04ae005b, 8'hFF, 8'h01}, '{32'h04aa005a, 8'hFE, 8'h00}
	};

	// Apply the first matching key code to the key state; no match keeps it
	function automatic logic [7:0] key_update(input logic [31:0] code, input logic [7:0] keys);
		logic       hit;
		logic [7:0] res;
		hit = 1'b0;
		res = keys;
		for (int k = 0; k < NUM_CODES; k++) begin
			if (!hit && code == KEY_TABLE[k].code) begin
				hit = 1'b1;
				res = (keys & KEY_TABLE[k].and_mask) | KEY_TABLE[k].or_mask;
			end
		end
		return res;
	endfunction

endpackage

[hdl/iekd_channels.sv]
// Stream channel interfaces of the input event key decoder.
interface iekd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] data_byte;

	modport source (output valid, action, data_byte, input ready);
	modport sink (input valid, action, data_byte, output ready);
endinterface

interface iekd_out_if;
	logic        valid;
	logic        ready;
	logic [8:0]  led_word;
	logic [31:0] packet_checksum;
	logic        unexpected_type;

	modport source (output valid, led_word, packet_checksum, unexpected_type, input ready);
	modport sink (input valid, led_word, packet_checksum, unexpected_type, output ready);
endinterface

[hdl/iekd_front.sv]
// Front end: accepts bytes, tracks packet framing and the running Adler-32.
module iekd_front (
	input  logic              clk,
	input  logic              arst_n,
	iekd_in_if.sink           stream,
	output logic              push_valid,
	input  logic              push_ready,
	output iekd_pkg::record_t push_rec
);

	logic [iekd_pkg::POS_W-1:0] pos_q;
	logic                       long_q;
	logic                       csum_en_q;
	logic                       unexp_q;
	logic [15:0]                sum_lo_q;
	logic [15:0]                sum_hi_q;

	logic        accept;
	logic        is_type;
	logic        long_n;
	logic        csum_en_n;
	logic        unexp_n;
	logic [7:0]  eff;
	logic [16:0] lo_sum;
	logic [16:0] hi_sum;
	logic [15:0] lo_n;
	logic [15:0] hi_n;
	logic        last;
	logic        is_data;
	logic        is_conn;
	logic        is_disc;

	assign stream.ready = push_ready;
	assign accept       = stream.valid && push_ready;

	assign is_data = stream.action == iekd_pkg::ACT_DATA;
	assign is_conn = stream.action == iekd_pkg::ACT_CONNECT;
	assign is_disc = stream.action == iekd_pkg::ACT_DISCONNECT;

	// Type byte classification
	assign is_type = pos_q == iekd_pkg::POS_TYPE;
	always_comb begin
		long_n    = long_q;
		csum_en_n = csum_en_q;
		unexp_n   = unexp_q;
		if (is_type) begin
			long_n    = stream.data_byte == iekd_pkg::TYPE_KEY ||
			            stream.data_byte == iekd_pkg::TYPE_KEYABS;
			csum_en_n = stream.data_byte == iekd_pkg::TYPE_ABS ||
			            stream.data_byte == iekd_pkg::TYPE_KEYABS;
			unexp_n   = !(stream.data_byte == iekd_pkg::TYPE_SYNC ||
			              stream.data_byte == iekd_pkg::TYPE_KEY ||
			              stream.data_byte == iekd_pkg::TYPE_ABS ||
			              stream.data_byte == iekd_pkg::TYPE_KEYABS);
		end
	end

	// Adler-32 step; the first half of each 16-byte block of a packet counts as zero
	assign eff    = pos_q[3] ? stream.data_byte : 8'h00;
	assign lo_sum = {1'b0, sum_lo_q} + {9'b0, eff};
	assign lo_n   = (lo_sum >= iekd_pkg::ADLER_MOD) ? 16'(lo_sum - iekd_pkg::ADLER_MOD)
	                                                : lo_sum[15:0];
	assign hi_sum = {1'b0, sum_hi_q} + {1'b0, lo_n};
	assign hi_n   = (hi_sum >= iekd_pkg::ADLER_MOD) ? 16'(hi_sum - iekd_pkg::ADLER_MOD)
	                                                : hi_sum[15:0];

	assign last = pos_q == iekd_pkg::POS_LAST_LONG ||
	              (pos_q == iekd_pkg::POS_LAST_SHORT && !long_n);

	// Record toward the back end
	assign push_valid = stream.valid && (is_conn || is_disc || (is_data && last));
	always_comb begin
		push_rec.sum   = 32'h0;
		push_rec.unexp = 1'b0;
		if (is_conn) begin
			push_rec.kind = iekd_pkg::REC_CONNECT;
		end else if (is_disc) begin
			push_rec.kind = iekd_pkg::REC_DISCONNECT;
		end else begin
			push_rec.kind  = iekd_pkg::REC_PACKET;
			push_rec.sum   = csum_en_n ? {hi_n, lo_n} : 32'h0;
			push_rec.unexp = unexp_n;
		end
	end

	// Packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			long_q    <= 1'b0;
			csum_en_q <= 1'b0;
			unexp_q   <= 1'b0;
			sum_lo_q  <= 16'd1;
			sum_hi_q  <= 16'd0;
		end else if (accept) begin
			if (is_conn || is_disc || (is_data && last)) begin
				pos_q     <= '0;
				long_q    <= 1'b0;
				csum_en_q <= 1'b0;
				unexp_q   <= 1'b0;
				sum_lo_q  <= 16'd1;
				sum_hi_q  <= 16'd0;
			end else if (is_data) begin
				pos_q     <= pos_q + 1'b1;
				long_q    <= long_n;
				csum_en_q <= csum_en_n;
				unexp_q   <= unexp_n;
				sum_lo_q  <= lo_n;
				sum_hi_q  <= hi_n;
			end
		end
	end

endmodule

[hdl/iekd_fifo.sv]
// Short record queue between the front and back ends.
module iekd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  iekd_pkg::record_t push_rec,
	output logic              pop_valid,
	input  logic              pop_ready,
	output iekd_pkg::record_t pop_rec
);

	iekd_pkg::record_t            entries_q [iekd_pkg::FIFO_DEPTH];
	logic [iekd_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [iekd_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [iekd_pkg::FIFO_CW-1:0] count_q;
	logic                         push;
	logic                         pop;

	assign push_ready = count_q != iekd_pkg::FIFO_CW'(iekd_pkg::FIFO_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_rec    = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_rec;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == iekd_pkg::FIFO_AW'(iekd_pkg::FIFO_DEPTH - 1)) ?
				            '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == iekd_pkg::FIFO_AW'(iekd_pkg::FIFO_DEPTH - 1)) ?
				            '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/iekd_back.sv]
// Back end: key code match, key state and the result output register.
module iekd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rec_valid,
	output logic              rec_ready,
	input  iekd_pkg::record_t rec,
	iekd_out_if.source        result
);

	logic [7:0]                 keys_q;
	logic                       out_valid_q;
	logic [iekd_pkg::LED_W-1:0] led_q;
	logic [31:0]                sum_q;
	logic                       unexp_q;
	logic                       pop;
	logic [7:0]                 keys_n;

	assign rec_ready = !out_valid_q || result.ready;
	assign pop       = rec_valid && rec_ready;

	assign result.valid           = out_valid_q;
	assign result.led_word        = led_q;
	assign result.packet_checksum = sum_q;
	assign result.unexpected_type = unexp_q;

	// Next key state for the record at the head of the queue
	always_comb begin
		unique case (rec.kind)
			iekd_pkg::REC_PACKET:     keys_n = iekd_pkg::key_update(rec.sum, keys_q);
			iekd_pkg::REC_CONNECT:    keys_n = 8'h00;
			iekd_pkg::REC_DISCONNECT: keys_n = keys_q;
			default:                  keys_n = keys_q;
		endcase
	end

	// Control: key state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q      <= 8'h00;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				keys_q      <= keys_n;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			sum_q   <= rec.sum;
			unexp_q <= rec.unexp;
			if (rec.kind == iekd_pkg::REC_DISCONNECT) begin
				led_q <= iekd_pkg::LED_DISCONNECT;
			end else begin
				led_q <= {1'b0, keys_n};
			end
		end
	end

endmodule

[hdl/input_event_key_decoder_unit.sv]
// Top level of the input event key decoder.
//
//   channel  dir  payload                                       transfer
//   stream   in   action[1:0], data_byte[7:0]                   valid && ready
//   result   out  led_word[8:0], packet_checksum[31:0],         valid && ready
//                 unexpected_type
//
// One byte per cycle is taken while the record queue has room; the front updates
// framing and Adler-32 in the cycle of the transfer. With no stall, the result of
// the byte that ends a packet (or of a connect/disconnect) is written into the
// record queue and from there into the output register, where it can be taken.
// Reset clears key state, packet framing and the record queue at once.
// A stalled result fills the two-entry record queue; stream.ready drops only
// when the queue is full.
module input_event_key_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	iekd_in_if.sink    stream,
	iekd_out_if.source result
);

	logic              push_valid;
	logic              push_ready;
	iekd_pkg::record_t push_rec;
	logic              pop_valid;
	logic              pop_ready;
	iekd_pkg::record_t pop_rec;

	iekd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (stream),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_rec   (push_rec)
	);

	iekd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_rec   (push_rec),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_rec    (pop_rec)
	);

	iekd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (pop_valid),
		.rec_ready (pop_ready),
		.rec       (pop_rec),
		.result    (result)
	);

endmodule
